// File: sv/stk_pkg.sv
// ----------------------------------------------------------------------------
// stk_pkg
// Types, register indexes, reset words and helper functions for the
// seed-to-key shift register core.
// ----------------------------------------------------------------------------
`default_nettype none

package stk_pkg;

  localparam int WORD_W      = 32;
  localparam int LEVEL_W     = 8;
  localparam int CFG_INDEX_W = 8;
  localparam int COUNT_W     = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_ONE   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_THREE = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_FIVE  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_SEVEN = 8'd3;

  localparam logic [LEVEL_W-1:0] LEVEL_THREE = 8'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_FIVE  = 8'd5;
  localparam logic [LEVEL_W-1:0] LEVEL_SEVEN = 8'd7;

  localparam logic [WORD_W-1:0] RST_LEVEL_ONE   = 32'h5f9e_a12a;
  localparam logic [WORD_W-1:0] RST_LEVEL_THREE = 32'hdcdf_e990;
  localparam logic [WORD_W-1:0] RST_LEVEL_FIVE  = 32'h5d9a_91ca;
  localparam logic [WORD_W-1:0] RST_LEVEL_SEVEN = 32'hdada_7a30;

  localparam logic [COUNT_W-1:0] MIX_XOR_B = 8'hA5;
  localparam logic [COUNT_W-1:0] MIX_XOR_C = 8'h5A;

  localparam int TAP_A = 29;
  localparam int TAP_B = 24;
  localparam int TAP_C = 13;
  localparam int TAP_D = 3;

  typedef struct packed {
    logic                   valid;
    logic [CFG_INDEX_W-1:0] index;
    logic [WORD_W-1:0]      data;
  } cfg_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOAD  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_FIN   = 4'b1000
  } eng_state_t;

  // step count from the constant word and the seed byte it picks
  function automatic logic [COUNT_W-1:0] step_count(input logic [WORD_W-1:0] c,
                                                    input logic [WORD_W-1:0] s);
    logic [1:0]         sel;
    logic [COUNT_W-1:0] b;
    logic [COUNT_W-1:0] d1;
    logic [COUNT_W-1:0] d2;
    logic [COUNT_W-1:0] d3;
    sel = {c[12], c[22]};
    case (sel)
      2'd0:    b = s[7:0];
      2'd1:    b = s[15:8];
      2'd2:    b = s[23:16];
      default: b = s[31:24];
    endcase
    d1 = c[10:3];
    d2 = c[30:23] ^ MIX_XOR_B;
    d3 = c[21:14] ^ MIX_XOR_C;
    return ((b ^ d1) & d2) + d3;
  endfunction

  function automatic logic [WORD_W-1:0] shift_once(input logic [WORD_W-1:0] s);
    return {s[WORD_W-2:0], s[TAP_A] ^ s[TAP_B] ^ s[TAP_C] ^ s[TAP_D]};
  endfunction

  function automatic logic [WORD_W-1:0] permute_bytes(input logic [WORD_W-1:0] s);
    return {s[15:8], s[7:0], s[23:16], s[31:24]};
  endfunction

endpackage

`default_nettype wire

// File: sv/stk_cfg_regs.sv
// ----------------------------------------------------------------------------
// stk_cfg_regs
// One constant word for each of four access levels, written over the
// configuration channel; selects the word for the requested level.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire stk_pkg::cfg_wr_t             wr,
  input  wire logic [stk_pkg::LEVEL_W-1:0]  level,
  output logic      [stk_pkg::WORD_W-1:0]   const_word
);

  logic [stk_pkg::WORD_W-1:0] c_one;
  logic [stk_pkg::WORD_W-1:0] c_three;
  logic [stk_pkg::WORD_W-1:0] c_five;
  logic [stk_pkg::WORD_W-1:0] c_seven;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_one   <= stk_pkg::RST_LEVEL_ONE;
      c_three <= stk_pkg::RST_LEVEL_THREE;
      c_five  <= stk_pkg::RST_LEVEL_FIVE;
      c_seven <= stk_pkg::RST_LEVEL_SEVEN;
    end else if (wr.valid) begin
      case (wr.index)
        stk_pkg::REG_LEVEL_ONE:   c_one   <= wr.data;
        stk_pkg::REG_LEVEL_THREE: c_three <= wr.data;
        stk_pkg::REG_LEVEL_FIVE:  c_five  <= wr.data;
        stk_pkg::REG_LEVEL_SEVEN: c_seven <= wr.data;
        default: ;
      endcase
    end
  end

  // unlisted levels fall back to the level-one word
  always_comb begin
    case (level)
      stk_pkg::LEVEL_THREE: const_word = c_three;
      stk_pkg::LEVEL_FIVE:  const_word = c_five;
      stk_pkg::LEVEL_SEVEN: const_word = c_seven;
      default:              const_word = c_one;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/stk_lfsr_engine.sv
// ----------------------------------------------------------------------------
// stk_lfsr_engine
// Sequencer around a single shift register step: loads the seed, works out
// the step count, clocks the register once per cycle, then forms the key.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_lfsr_engine (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [stk_pkg::WORD_W-1:0]  seed,
  input  wire logic [stk_pkg::WORD_W-1:0]  const_word,
  output logic                             busy,
  output logic                             done,
  output logic      [stk_pkg::WORD_W-1:0]  key
);

  stk_pkg::eng_state_t state;
  stk_pkg::eng_state_t state_next;

  logic [stk_pkg::WORD_W-1:0]  sreg;
  logic [stk_pkg::WORD_W-1:0]  cword;
  logic [stk_pkg::COUNT_W-1:0] count;
  logic [stk_pkg::WORD_W-1:0]  perm;

  assign busy = (state != stk_pkg::ST_IDLE);
  assign perm = cword[1] ? stk_pkg::permute_bytes(sreg) : sreg;

  always_comb begin
    state_next = state;
    case (state)
      stk_pkg::ST_IDLE:  if (start) state_next = stk_pkg::ST_LOAD;
      stk_pkg::ST_LOAD:  state_next = stk_pkg::ST_SHIFT;
      stk_pkg::ST_SHIFT: if (count == '0) state_next = stk_pkg::ST_FIN;
      stk_pkg::ST_FIN:   state_next = stk_pkg::ST_IDLE;
      default:           state_next = stk_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stk_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == stk_pkg::ST_FIN);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      stk_pkg::ST_IDLE: begin
        if (start) begin
          sreg  <= seed;
          cword <= const_word;
        end
      end
      stk_pkg::ST_LOAD: begin
        count <= stk_pkg::step_count(cword, sreg);
      end
      stk_pkg::ST_SHIFT: begin
        if (count != '0) begin
          sreg  <= stk_pkg::shift_once(sreg);
          count <= count - 1'b1;
        end
      end
      stk_pkg::ST_FIN: begin
        key <= perm ^ cword;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/seed_to_key_lfsr_core.sv
// ----------------------------------------------------------------------------
// seed_to_key_lfsr_core
// Seed-to-key calculator: a 32-bit seed and an access level in, one 32-bit
// key out, via a level-selected constant and a stepped shift register.
// ----------------------------------------------------------------------------
// Usage
//   Request: drive seed and access_level with start high; the word is taken
//   at a rising edge where start is high and busy is low. busy then stays
//   high until the key is ready.
//   Result: key is valid for the single cycle in which done is high; the
//   receiver cannot stall, so it must take the word in that cycle. key
//   holds its value until the next result.
//   Sequence: after the accepting edge the engine loads, computes the step
//   count n (0..255) from the constant and the seed, shifts n times at one
//   step per cycle, then forms the key and raises done. A new request can
//   be accepted in the done cycle itself.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data write the
//   four constant words (index 0..3); other indexes are ignored. cfg_ready
//   is always high. Write only while busy is low.
//   Reset: rst (synchronous) returns to idle and reloads the default words.
// ----------------------------------------------------------------------------
`default_nettype none

module seed_to_key_lfsr_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [stk_pkg::WORD_W-1:0]       seed,
  input  wire logic [stk_pkg::LEVEL_W-1:0]      access_level,
  output logic                                  done,
  output logic      [stk_pkg::WORD_W-1:0]       key,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [stk_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [stk_pkg::WORD_W-1:0]       cfg_data
);

  stk_pkg::cfg_wr_t           wr;
  logic [stk_pkg::WORD_W-1:0] const_word;

  assign cfg_ready = 1'b1;
  assign wr.valid  = cfg_valid & cfg_ready;
  assign wr.index  = cfg_index;
  assign wr.data   = cfg_data;

  stk_cfg_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .level      (access_level),
    .const_word (const_word)
  );

  stk_lfsr_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .seed       (seed),
    .const_word (const_word),
    .busy       (busy),
    .done       (done),
    .key        (key)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for seed_to_key_lfsr_core. Requests (seed, level) are
// queued by the stimulus block and issued in random bursts by a clocked
// driver. Each accepted word is scored by an in-bench key calculator that
// keeps its own copy of the four level words, and every done strobe is
// compared against the oldest predicted key. The level words are rewritten
// between phases, covering all-zero, all-one, zero-step and full-step forms.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 228;
  localparam logic [stk_pkg::WORD_W-1:0] FEEDBACK_TAPS =
    (32'd1 << stk_pkg::TAP_A) | (32'd1 << stk_pkg::TAP_B) |
    (32'd1 << stk_pkg::TAP_C) | (32'd1 << stk_pkg::TAP_D);
  localparam logic [1:0] IDX_ONE   = 2'(stk_pkg::REG_LEVEL_ONE);
  localparam logic [1:0] IDX_THREE = 2'(stk_pkg::REG_LEVEL_THREE);
  localparam logic [1:0] IDX_FIVE  = 2'(stk_pkg::REG_LEVEL_FIVE);
  localparam logic [1:0] IDX_SEVEN = 2'(stk_pkg::REG_LEVEL_SEVEN);

  typedef struct packed {
    logic [stk_pkg::WORD_W-1:0]  seed;
    logic [stk_pkg::LEVEL_W-1:0] level;
  } key_request_t;

  typedef struct packed {
    key_request_t               req;
    logic [stk_pkg::WORD_W-1:0] key;
  } key_expect_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  logic                            busy;
  logic [stk_pkg::WORD_W-1:0]      seed = '0;
  logic [stk_pkg::LEVEL_W-1:0]     access_level = '0;
  logic                            done;
  logic [stk_pkg::WORD_W-1:0]      key;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [stk_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [stk_pkg::WORD_W-1:0]      cfg_data = '0;

  logic [stk_pkg::WORD_W-1:0] level_word [4];
  key_request_t               request_q[$];
  key_expect_t                key_expect_q[$];
  int                         n_errors = 0;
  int                         cycle_count = 0;
  int                         burst_left = 1;
  int                         gap_left = 0;

  seed_to_key_lfsr_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .seed         (seed),
    .access_level (access_level),
    .done         (done),
    .key          (key),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [stk_pkg::WORD_W-1:0] calc_key(input key_request_t r);
    logic [stk_pkg::WORD_W-1:0] c;
    logic [stk_pkg::WORD_W-1:0] sr;
    logic [1:0]                 pick;
    logic [7:0]                 b;
    logic [7:0]                 steps;
    case (r.level)
      stk_pkg::LEVEL_THREE: c = level_word[IDX_THREE];
      stk_pkg::LEVEL_FIVE:  c = level_word[IDX_FIVE];
      stk_pkg::LEVEL_SEVEN: c = level_word[IDX_SEVEN];
      default:              c = level_word[IDX_ONE];
    endcase
    pick  = {c[12], c[22]};
    b     = r.seed[8*pick +: 8];
    steps = ((b ^ c[10:3]) & (c[30:23] ^ stk_pkg::MIX_XOR_B)) +
            (c[21:14] ^ stk_pkg::MIX_XOR_C);
    sr    = r.seed;
    for (int i = 0; i < steps; i++) begin
      sr = {sr[stk_pkg::WORD_W-2:0], ^(sr & FEEDBACK_TAPS)};
    end
    // bytes 1,0 to the top, byte 2 to byte 1, byte 3 to byte 0
    if (c[1]) begin
      sr = {sr[15:0], sr[23:16], sr[31:24]};
    end
    return sr ^ c;
  endfunction

  task automatic queue_request(input logic [stk_pkg::WORD_W-1:0] s,
                               input logic [stk_pkg::LEVEL_W-1:0] lvl);
    key_request_t r;
    r.seed  = s;
    r.level = lvl;
    request_q.push_back(r);
  endtask

  task automatic write_level_word(input logic [stk_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [stk_pkg::WORD_W-1:0] w);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= stk_pkg::REG_LEVEL_SEVEN) begin
      level_word[idx[1:0]] = w;
    end
  endtask

  task automatic wait_until_idle();
    while (request_q.size() != 0 || start || busy || key_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // request driver: bursts of words with random gaps
  always @(posedge clk) begin : request_driver
    key_request_t nxt;
    bit           free;
    if (rst) begin
      start <= 1'b0;
    end else begin
      free = (start && !busy) || !start;
      if (free) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (request_q.size() != 0) begin
          nxt = request_q.pop_front();
          seed         <= nxt.seed;
          access_level <= nxt.level;
          start        <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
              0, 1:    gap_left = 0;
              2:       gap_left = $urandom_range(1, 10);
              default: gap_left = $urandom_range(1, 300);
            endcase
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // scoreboard: check done strobes, then record the word taken at this edge
  always @(posedge clk) begin : key_monitor
    key_expect_t  want;
    key_expect_t  got;
    if (!rst) begin
      if (done) begin
        if (key_expect_q.size() == 0) begin
          if (n_errors < 10) $display("unexpected key %h", key);
          n_errors++;
        end else begin
          want = key_expect_q.pop_front();
          if (key !== want.key) begin
            if (n_errors < 10) begin
              $display("key mismatch seed %h level %0d: expected %h got %h",
                       want.req.seed, want.req.level, want.key, key);
            end
            n_errors++;
          end
        end
      end
      if (start && !busy) begin
        got.req.seed  = seed;
        got.req.level = access_level;
        got.key       = calc_key(got.req);
        key_expect_q.push_back(got);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[seed_to_key_lfsr_core] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [stk_pkg::WORD_W-1:0]  w;
    logic [stk_pkg::WORD_W-1:0]  s;
    logic [stk_pkg::LEVEL_W-1:0] lvl;
    level_word[IDX_ONE]   = stk_pkg::RST_LEVEL_ONE;
    level_word[IDX_THREE] = stk_pkg::RST_LEVEL_THREE;
    level_word[IDX_FIVE]  = stk_pkg::RST_LEVEL_FIVE;
    level_word[IDX_SEVEN] = stk_pkg::RST_LEVEL_SEVEN;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // default words, every listed level and a few unlisted ones
    queue_request(32'h0000_0000, 8'd1);
    queue_request(32'hffff_ffff, 8'd1);
    queue_request(32'h1234_5678, stk_pkg::LEVEL_THREE);
    queue_request(32'h8000_0001, stk_pkg::LEVEL_FIVE);
    queue_request(32'ha5a5_a5a5, stk_pkg::LEVEL_SEVEN);
    queue_request(32'h5a5a_5a5a, 8'd0);
    queue_request(32'hdead_beef, 8'd255);
    queue_request(32'h0f0f_f0f0, 8'd2);
    queue_request(32'hffff_ffff, stk_pkg::LEVEL_SEVEN);
    queue_request(32'h0000_0000, stk_pkg::LEVEL_THREE);
    queue_request(32'h7fff_ffff, 8'd4);
    queue_request(32'h0000_0001, 8'd6);
    wait_until_idle();

    // zero-step word, full-step word, all zeros, all ones; stray indexes ignored
    w = $urandom;
    w[30:23] = stk_pkg::MIX_XOR_B;
    w[21:14] = stk_pkg::MIX_XOR_C;
    w[1]     = 1'b1;
    write_level_word(stk_pkg::REG_LEVEL_ONE, w);
    w = $urandom;
    w[30:23] = stk_pkg::MIX_XOR_B;
    w[21:14] = ~stk_pkg::MIX_XOR_C;
    w[1]     = 1'b0;
    write_level_word(stk_pkg::REG_LEVEL_THREE, w);
    write_level_word(stk_pkg::REG_LEVEL_FIVE, 32'h0000_0000);
    write_level_word(stk_pkg::REG_LEVEL_SEVEN, 32'hffff_ffff);
    write_level_word(8'd4, $urandom);
    write_level_word(8'd255, $urandom);
    queue_request(32'h0000_0000, 8'd1);
    queue_request(32'hffff_ffff, 8'd9);
    queue_request(32'h0000_0000, stk_pkg::LEVEL_THREE);
    queue_request(32'hffff_ffff, stk_pkg::LEVEL_THREE);
    queue_request(32'h0000_0000, stk_pkg::LEVEL_FIVE);
    queue_request(32'hffff_ffff, stk_pkg::LEVEL_FIVE);
    queue_request(32'h0000_0000, stk_pkg::LEVEL_SEVEN);
    queue_request(32'hffff_ffff, stk_pkg::LEVEL_SEVEN);
    queue_request(32'hc3c3_3c3c, 8'd0);
    wait_until_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      for (int r = 0; r < 4; r++) begin
        w = $urandom;
        case ($urandom_range(0, 7))
          0:       w = '0;
          1:       w = '1;
          2:       begin
            w[30:23] = stk_pkg::MIX_XOR_B;
            w[21:14] = stk_pkg::MIX_XOR_C;
          end
          3:       begin
            w[30:23] = stk_pkg::MIX_XOR_B;
            w[21:14] = ~stk_pkg::MIX_XOR_C;
          end
          default: ;
        endcase
        write_level_word(r[stk_pkg::CFG_INDEX_W-1:0], w);
      end
      if ($urandom_range(0, 1)) begin
        write_level_word(stk_pkg::CFG_INDEX_W'($urandom_range(4, 255)), $urandom);
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        s = $urandom;
        case ($urandom_range(0, 15))
          0:       s = '0;
          1:       s = '1;
          default: ;
        endcase
        case ($urandom_range(0, 4))
          0:       lvl = 8'd1;
          1:       lvl = stk_pkg::LEVEL_THREE;
          2:       lvl = stk_pkg::LEVEL_FIVE;
          3:       lvl = stk_pkg::LEVEL_SEVEN;
          default: lvl = stk_pkg::LEVEL_W'($urandom_range(0, 255));
        endcase
        queue_request(s, lvl);
      end
      wait_until_idle();
    end

    repeat (300) @(posedge clk);
    if (n_errors == 0 && key_expect_q.size() == 0) begin
      $display("[seed_to_key_lfsr_core] OK");
    end else begin
      $display("[seed_to_key_lfsr_core] ERROR");
    end
    $finish;
  end

endmodule
